@@ src/rhc_pkg.sv @@
// Shared types and constants for the RGB/HSV color converter.
`default_nettype none
package rhc_pkg;

  // Operation codes
  localparam logic OP_RGB2HSV = 1'b0;
  localparam logic OP_HSV2RGB = 1'b1;

  // Hue is degrees times 64: one 60 degree sector and the full circle
  localparam logic [14:0] SECTOR = 15'd3840;
  localparam logic [14:0] CIRCLE = 15'd23040;
  localparam logic [14:0] BASE_G = 15'd7680;
  localparam logic [14:0] BASE_B = 15'd15360;

  // Hue sectors for the hsv to rgb direction
  localparam logic [2:0] SEC_RY = 3'd0;
  localparam logic [2:0] SEC_YG = 3'd1;
  localparam logic [2:0] SEC_GC = 3'd2;
  localparam logic [2:0] SEC_CB = 3'd3;
  localparam logic [2:0] SEC_BM = 3'd4;
  localparam logic [2:0] SEC_MR = 3'd5;

  // Entries in the queue between front and back
  localparam int unsigned QDEPTH = 2;

  typedef struct packed {
    logic        op;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
    logic [14:0] hue_in;
    logic [12:0] sat_in;
    logic [12:0] val_in;
  } rhc_in_t;

  typedef struct packed {
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic [14:0] hue_out;
    logic [12:0] sat_out;
    logic [12:0] val_out;
  } rhc_out_t;

  // Classified item: everything the back end needs, no division done yet
  typedef struct packed {
    logic        op;
    logic [7:0]  mx;     // max channel
    logic [7:0]  d;      // max minus min
    logic [7:0]  hx;     // magnitude of the hue numerator difference
    logic        hsub;   // subtract the hue quotient from the base
    logic [14:0] hbase;  // hue base of the sector
    logic [2:0]  hi;     // hue sector
    logic [11:0] fr;     // hue fraction within the sector
    logic [12:0] s;      // saturated saturation
    logic [12:0] v;      // saturated value
  } rhc_cls_t;

endpackage
`default_nettype wire

@@ src/rhc_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module rhc_div #(
  parameter int unsigned NW = 20,
  parameter int unsigned DW = 8,
  parameter int unsigned QW = 12
) (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output logic      [QW-1:0] quo_o
);

  localparam int unsigned RW = NW + DW + QW;

  logic [RW-1:0] rem_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] quo_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [RW-1:0] rem_in;
    logic [RW-1:0] sh;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [RW-1:0] rem_d;
    logic [QW-1:0] quo_d;

    if (k == 0) begin : g_first
      assign rem_in = RW'(num_i);
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign sh = RW'(den_in) << (QW - 1 - k);

    always_comb begin
      rem_d = rem_in;
      quo_d = quo_in;
      if (rem_in >= sh) begin
        rem_d = rem_in - sh;
        quo_d = quo_in | (QW'(1) << (QW - 1 - k));
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d;
        den_q[k] <= den_in;
        quo_q[k] <= quo_d;
      end
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule
`default_nettype wire

@@ src/rhc_front.sv @@
// Front end: classify an incoming item (sector, spread, hue sector and fraction, clipped s and v).
`default_nettype none
module rhc_front #(
  parameter int unsigned UNIT_BITS = 12
) (
  input  wire rhc_pkg::rhc_in_t item_i,
  output rhc_pkg::rhc_cls_t     cls_o
);
  import rhc_pkg::*;

  localparam logic [31:0] UNIT = 32'd1 << UNIT_BITS;

  logic [7:0]  r, g, b, mx, mn;
  logic [14:0] h, hoff;

  always_comb begin
    r  = item_i.red_in;
    g  = item_i.green_in;
    b  = item_i.blue_in;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;

    cls_o       = '0;
    cls_o.op    = item_i.op;
    cls_o.mx    = mx;
    cls_o.d     = mx - mn;

    // Red wins ties, then green
    if (mx == r) begin
      if (g >= b) begin
        cls_o.hbase = '0;
        cls_o.hsub  = 1'b0;
        cls_o.hx    = g - b;
      end else begin
        cls_o.hbase = CIRCLE;
        cls_o.hsub  = 1'b1;
        cls_o.hx    = b - g;
      end
    end else if (mx == g) begin
      cls_o.hbase = BASE_G;
      cls_o.hsub  = (b < r);
      cls_o.hx    = (b >= r) ? b - r : r - b;
    end else begin
      cls_o.hbase = BASE_B;
      cls_o.hsub  = (r < g);
      cls_o.hx    = (r >= g) ? r - g : g - r;
    end

    // Wrap hue once, then find its sector
    h = (item_i.hue_in >= CIRCLE) ? item_i.hue_in - CIRCLE : item_i.hue_in;
    if (h >= 15'(5 * 3840)) begin
      cls_o.hi = SEC_MR;
      hoff     = 15'(5 * 3840);
    end else if (h >= 15'(4 * 3840)) begin
      cls_o.hi = SEC_BM;
      hoff     = 15'(4 * 3840);
    end else if (h >= 15'(3 * 3840)) begin
      cls_o.hi = SEC_CB;
      hoff     = 15'(3 * 3840);
    end else if (h >= 15'(2 * 3840)) begin
      cls_o.hi = SEC_GC;
      hoff     = 15'(2 * 3840);
    end else if (h >= SECTOR) begin
      cls_o.hi = SEC_YG;
      hoff     = SECTOR;
    end else begin
      cls_o.hi = SEC_RY;
      hoff     = '0;
    end
    cls_o.fr = 12'(h - hoff);

    // Clip saturation and value to one unit
    cls_o.s = ({19'd0, item_i.sat_in} > UNIT) ? UNIT[12:0] : item_i.sat_in;
    cls_o.v = ({19'd0, item_i.val_in} > UNIT) ? UNIT[12:0] : item_i.val_in;
  end

endmodule
`default_nettype wire

@@ src/rhc_fifo.sv @@
// Short queue of classified items between the front and back ends.
`default_nettype none
module rhc_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire rhc_pkg::rhc_cls_t data_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   empty_o,
  output rhc_pkg::rhc_cls_t      data_o
);
  import rhc_pkg::*;

  localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CW = $clog2(QDEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(QDEPTH - 1);

  rhc_cls_t      mem_q [QDEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) wr_d = (wr_q == LAST) ? '0 : wr_q + PW'(1);
    if (pop_i)  rd_d = (rd_q == LAST) ? '0 : rd_q + PW'(1);
    if (push_i && !pop_i) cnt_d = cnt_q + CW'(1);
    if (!push_i && pop_i) cnt_d = cnt_q - CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule
`default_nettype wire

@@ src/rhc_back.sv @@
// Back end: divider pipelines and fixed point term arithmetic, then result select.
`default_nettype none
module rhc_back #(
  parameter int unsigned UNIT_BITS = 12
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              adv_i,
  input  wire logic              vld_i,
  input  wire rhc_pkg::rhc_cls_t cls_i,
  output logic                   vld_o,
  output rhc_pkg::rhc_out_t      res_o
);
  import rhc_pkg::*;

  localparam int unsigned UB = UNIT_BITS;
  localparam int unsigned DS = (UB + 1 > 12) ? UB + 1 : 12;  // divider stages
  localparam int unsigned RD = DS - 4;                       // side result delay
  localparam int unsigned SW = UB + 1;
  localparam int unsigned FW = UB + 13;
  localparam int unsigned TW = UB + 12;
  localparam int unsigned VW = UB + 9;
  localparam int unsigned PW = 2 * UB + 21;
  localparam int unsigned XW = UB + 8;
  localparam int unsigned GW = UB + 17;
  localparam logic [SW-1:0] UNIT = SW'(1) << UB;
  localparam logic [TW-1:0] USC  = TW'(3840) << UB;

  typedef struct packed {
    logic [SW-1:0] val;
    logic [7:0]    tv;
    logic [7:0]    tp;
    logic [7:0]    tq;
    logic [7:0]    tt;
  } rhc_side_t;

  // Estimate y / 15 from below (off by at most one)
  function automatic logic [8:0] div15_est(input logic [11:0] y);
    logic [24:0] p;
    p = 25'(y) * 25'd4369;
    return p[24:16];
  endfunction

  function automatic logic [7:0] div15_fix(input logic [11:0] y, input logic [8:0] q);
    logic [11:0] rem;
    logic [8:0]  qc;
    rem = y - 12'(q) * 12'd15;
    qc  = (rem >= 12'd15) ? q + 9'd1 : q;
    return qc[7:0];
  endfunction

  // Valid chain and classified item alongside the dividers
  logic [DS-1:0] vld_q;
  rhc_cls_t      cls_q [DS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[DS-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      cls_q[0] <= cls_i;
      for (int k = 1; k < DS; k++) cls_q[k] <= cls_q[k-1];
    end
  end

  // Hue and saturation dividers
  logic [DS-1:0] hq, sq;

  rhc_div #(.NW(20), .DW(8), .QW(DS)) u_hdiv (
    .clk_i (clk_i),
    .en_i  (adv_i),
    .num_i (20'(cls_i.hx) * 20'd3840),
    .den_i (cls_i.d),
    .quo_o (hq)
  );

  rhc_div #(.NW(XW), .DW(8), .QW(DS)) u_sdiv (
    .clk_i (clk_i),
    .en_i  (adv_i),
    .num_i ({cls_i.d, {UB{1'b0}}}),
    .den_i (cls_i.mx),
    .quo_o (sq)
  );

  // Stage 1: products on s, v and the value reciprocal estimate
  logic [SW-1:0] sw, vw;
  logic [GW-1:0] vprod;
  logic [FW-1:0] s1_fs_q, s1_fcs_q;
  logic [SW-1:0] s1_us_q, s1_q0v_q;
  logic [VW-1:0] s1_v255_q;

  assign sw    = SW'(cls_i.s);
  assign vw    = SW'(cls_i.v);
  assign vprod = GW'({cls_i.mx, {UB{1'b0}}}) * GW'(257);

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_fs_q   <= FW'(cls_i.fr) * FW'(sw);
      s1_fcs_q  <= FW'(12'd3840 - cls_i.fr) * FW'(sw);
      s1_us_q   <= UNIT - sw;
      s1_v255_q <= VW'(vw) * VW'(255);
      s1_q0v_q  <= vprod[UB+16:16];
    end
  end

  // Stage 2: the three bracketed terms and the value remainder
  logic [VW-1:0] rv;
  logic [TW-1:0] s2_tp_q, s2_tq_q, s2_tt_q;
  logic [VW-1:0] s2_v255_q;
  logic [9:0]    s2_r0_q;
  logic [SW-1:0] s2_q0v_q;

  assign rv = VW'({cls_q[0].mx, {UB{1'b0}}}) - VW'(s1_q0v_q) * VW'(255);

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s2_tp_q   <= TW'(s1_us_q) * TW'(3840);
      s2_tq_q   <= USC - s1_fs_q[TW-1:0];
      s2_tt_q   <= USC - s1_fcs_q[TW-1:0];
      s2_v255_q <= s1_v255_q;
      s2_r0_q   <= rv[9:0];
      s2_q0v_q  <= s1_q0v_q;
    end
  end

  // Stage 3: 255 * v * term, and the corrected value
  logic [PW-1:0] s3_pp_q, s3_pq_q, s3_pt_q;
  logic [7:0]    s3_tv_q;
  logic [SW-1:0] s3_val_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s3_pp_q  <= PW'(s2_v255_q) * PW'(s2_tp_q);
      s3_pq_q  <= PW'(s2_v255_q) * PW'(s2_tq_q);
      s3_pt_q  <= PW'(s2_v255_q) * PW'(s2_tt_q);
      s3_tv_q  <= s2_v255_q[UB+7:UB];
      if (s2_r0_q >= 10'd510)      s3_val_q <= s2_q0v_q + SW'(2);
      else if (s2_r0_q >= 10'd255) s3_val_q <= s2_q0v_q + SW'(1);
      else                         s3_val_q <= s2_q0v_q;
    end
  end

  // Stage 4: drop the power of two part of the divisor, estimate the divide by 15
  logic [11:0] yp, yq, yt;
  logic [11:0] s4_yp_q, s4_yq_q, s4_yt_q;
  logic [8:0]  s4_qp_q, s4_qq_q, s4_qt_q;
  logic [7:0]  s4_tv_q;
  logic [SW-1:0] s4_val_q;

  assign yp = s3_pp_q[2*UB+19:2*UB+8];
  assign yq = s3_pq_q[2*UB+19:2*UB+8];
  assign yt = s3_pt_q[2*UB+19:2*UB+8];

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s4_yp_q  <= yp;
      s4_yq_q  <= yq;
      s4_yt_q  <= yt;
      s4_qp_q  <= div15_est(yp);
      s4_qq_q  <= div15_est(yq);
      s4_qt_q  <= div15_est(yt);
      s4_tv_q  <= s3_tv_q;
      s4_val_q <= s3_val_q;
    end
  end

  // Stage 5 and delay to line up with the dividers
  rhc_side_t res_q [RD];

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      res_q[0].val <= s4_val_q;
      res_q[0].tv  <= s4_tv_q;
      res_q[0].tp  <= div15_fix(s4_yp_q, s4_qp_q);
      res_q[0].tq  <= div15_fix(s4_yq_q, s4_qq_q);
      res_q[0].tt  <= div15_fix(s4_yt_q, s4_qt_q);
      for (int k = 1; k < RD; k++) res_q[k] <= res_q[k-1];
    end
  end

  // Result select
  rhc_cls_t  c;
  rhc_side_t sd;
  logic [31:0] sq32, val32;

  assign c     = cls_q[DS-1];
  assign sd    = res_q[RD-1];
  assign sq32  = 32'(sq);
  assign val32 = 32'(sd.val);
  assign vld_o = vld_q[DS-1];

  always_comb begin
    res_o = '0;
    if (c.op == OP_RGB2HSV) begin
      if (c.d != 8'd0) begin
        res_o.hue_out = c.hsub ? c.hbase - 15'(hq[11:0]) : c.hbase + 15'(hq[11:0]);
      end
      if (c.mx != 8'd0) res_o.sat_out = sq32[12:0];
      res_o.val_out = val32[12:0];
    end else begin
      case (c.hi)
        SEC_RY: begin
          res_o.red_out = sd.tv; res_o.green_out = sd.tt; res_o.blue_out = sd.tp;
        end
        SEC_YG: begin
          res_o.red_out = sd.tq; res_o.green_out = sd.tv; res_o.blue_out = sd.tp;
        end
        SEC_GC: begin
          res_o.red_out = sd.tp; res_o.green_out = sd.tv; res_o.blue_out = sd.tt;
        end
        SEC_CB: begin
          res_o.red_out = sd.tp; res_o.green_out = sd.tq; res_o.blue_out = sd.tv;
        end
        SEC_BM: begin
          res_o.red_out = sd.tt; res_o.green_out = sd.tp; res_o.blue_out = sd.tv;
        end
        default: begin
          res_o.red_out = sd.tv; res_o.green_out = sd.tp; res_o.blue_out = sd.tq;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ src/rgb_hsv_converter.sv @@
// Top level of the RGB/HSV color converter: queue ports, front, queue, back, result register.
// Path from push to result: queue, back pipeline, result register; D = max(UNIT_BITS + 1, 12)
//   is the depth of the one-bit-per-stage divider pipelines in the back end.
// Throughput: one transaction per cycle; the back pipeline advances whenever the result
//   register is empty or being popped.
// Reset: asynchronous, active low; clears the queue and all valid flags, so empty is high.
`default_nettype none
module rgb_hsv_converter #(
  parameter int unsigned UNIT_BITS = 12
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push,
  output logic                  full,
  input  wire rhc_pkg::rhc_in_t item_i,
  output logic                  empty,
  input  wire logic             pop,
  output rhc_pkg::rhc_out_t     result_o
);
  import rhc_pkg::*;

  // Classify the incoming transaction combinationally; the queue holds the outcome
  rhc_cls_t cls_in, cls_head;
  logic     q_full, q_empty, q_push, q_pop;

  rhc_front #(.UNIT_BITS(UNIT_BITS)) u_front (
    .item_i (item_i),
    .cls_o  (cls_in)
  );

  assign full   = q_full;
  assign q_push = push && !q_full;

  rhc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (cls_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (cls_head)
  );

  // Advance the whole back pipeline when the result register can take a new value
  logic     out_vld_q, out_vld_d, adv, back_vld;
  rhc_out_t out_q, back_res;

  assign adv   = !out_vld_q || pop;
  assign q_pop = adv && !q_empty;

  rhc_back #(.UNIT_BITS(UNIT_BITS)) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (q_pop),
    .cls_i  (cls_head),
    .vld_o  (back_vld),
    .res_o  (back_res)
  );

  // Result register: hold while stalled, load the pipeline tail on advance
  always_comb begin
    out_vld_d = out_vld_q;
    if (adv) out_vld_d = back_vld;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && back_vld) out_q <= back_res;
  end

  assign empty    = !out_vld_q;
  assign result_o = out_q;

  // Only one direction's fields carry a result
  a_one_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (result_o.red_out == 8'd0 && result_o.green_out == 8'd0 &&
                result_o.blue_out == 8'd0) ||
               (result_o.hue_out == 15'd0 && result_o.sat_out == 13'd0 &&
                result_o.val_out == 13'd0))
    else $error("result carries fields of both directions");

  // Hue stays on the circle
  a_hue_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> result_o.hue_out < CIRCLE)
    else $error("hue out of range");

  // Zero value means black, which has no hue and no saturation
  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (UNIT_BITS <= 12) && !empty && result_o.val_out == 13'd0 |->
      result_o.hue_out == 15'd0 && result_o.sat_out == 13'd0)
    else $error("zero value with nonzero hue or saturation");

endmodule
`default_nettype wire
